### rtl/yuv420_pkg.sv
// Shared types and constants for the YUYV 4:2:2 to planar 4:2:0 converter.
// No dependencies; imported by every module of the block except yuv420_ram.
`default_nettype none

package yuv420_pkg;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int PAIR_CNT_W = 10;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_PAIRS_PER_LINE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PAIRS_PER_FRAME = 2'd1;

    // Register reset values
    localparam logic [CFG_W-1:0] PAIRS_PER_LINE_RESET       = 11'd320;
    localparam logic [CFG_W-1:0] LINE_PAIRS_PER_FRAME_RESET = 11'd240;

    // Upper clamp of the line pair count, and default line buffer depth
    localparam logic [CFG_W-1:0] LINE_PAIR_LIMIT = 11'd1024;
    localparam int               MAX_PAIRS_DEF   = 1024;

    // One input macropixel, packed as it sits on tdata (last field lowest)
    typedef struct packed {
        logic [PIX_W-1:0] chroma_red;
        logic [PIX_W-1:0] luma_second;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] luma_first;
    } t_pix;

    // Per-beat info handed from the counter logic to the averaging stage
    typedef struct packed {
        logic [PIX_W-1:0] luma_first;
        logic [PIX_W-1:0] luma_second;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
        logic             chroma_valid;
        logic             line_end;
        logic             frame_end;
    } t_meta;

    // One result beat
    typedef struct packed {
        logic [PIX_W-1:0] y_out_first;
        logic [PIX_W-1:0] y_out_second;
        logic [PIX_W-1:0] u_average;
        logic [PIX_W-1:0] v_average;
        logic             chroma_valid;
        logic             line_end;
        logic             frame_end;
    } t_result;

endpackage

`default_nettype wire

### rtl/yuv420_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module yuv420_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/yuv420_ctrl.sv
// Configuration registers, column / line / pair counters and line buffer addressing.
// Depends on yuv420_pkg.
`default_nettype none

module yuv420_ctrl
    import yuv420_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_W-1:0]             i_cfg_data,
    input  wire logic                         i_accept,
    input  wire t_pix                         i_pix,
    output logic                              o_ram_we,
    output logic                              o_ram_re,
    output logic      [$clog2(MAX_PAIRS)-1:0] o_ram_addr,
    output logic      [2*PIX_W-1:0]           o_ram_wdata,
    output t_meta                             o_meta
);

    localparam int AW = $clog2(MAX_PAIRS);
    localparam int MW = $clog2(MAX_PAIRS + 1);
    localparam int CW = (MW > CFG_W) ? MW : CFG_W;
    localparam logic [CW-1:0] MAXP = CW'(MAX_PAIRS);

    logic [CFG_W-1:0]      r_pairs_per_line;
    logic [CFG_W-1:0]      r_line_pairs;
    logic [AW-1:0]         r_col;
    logic                  r_second;
    logic [PAIR_CNT_W-1:0] r_pair;

    logic [AW-1:0]         n_col;
    logic                  n_second;
    logic [PAIR_CNT_W-1:0] n_pair;

    logic [CW-1:0]    ppl_ext;
    logic [CW-1:0]    width;
    logic [CW-1:0]    col_ext;
    logic [CW-1:0]    col_eff;
    logic [CW-1:0]    col_next;
    logic [CFG_W-1:0] height;
    logic [CFG_W-1:0] pair_next;
    logic             last_col;
    logic             last_pair;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs_per_line <= PAIRS_PER_LINE_RESET;
            r_line_pairs     <= LINE_PAIRS_PER_FRAME_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PAIRS_PER_LINE:       r_pairs_per_line <= i_cfg_data;
                CFG_LINE_PAIRS_PER_FRAME: r_line_pairs     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp line width and frame height, find the last column / pair
    always_comb begin
        ppl_ext = CW'(r_pairs_per_line);
        if (ppl_ext == '0) begin
            width = CW'(1);
        end else if (ppl_ext > MAXP) begin
            width = MAXP;
        end else begin
            width = ppl_ext;
        end

        if (r_line_pairs == '0) begin
            height = CFG_W'(1);
        end else if (r_line_pairs > LINE_PAIR_LIMIT) begin
            height = LINE_PAIR_LIMIT;
        end else begin
            height = r_line_pairs;
        end

        // A column left past the end by a width change counts as the last one
        col_ext   = CW'(r_col);
        col_eff   = (col_ext >= width) ? (width - CW'(1)) : col_ext;
        col_next  = col_eff + CW'(1);
        last_col  = (col_next >= width);
        pair_next = CFG_W'(r_pair) + CFG_W'(1);
        last_pair = (pair_next >= height);
    end

    // Counter advance
    always_comb begin
        n_col    = r_col;
        n_second = r_second;
        n_pair   = r_pair;
        if (!last_col) begin
            n_col = col_next[AW-1:0];
        end else begin
            n_col = '0;
            if (!r_second) begin
                n_second = 1'b1;
            end else begin
                n_second = 1'b0;
                n_pair   = last_pair ? '0 : pair_next[PAIR_CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_second <= 1'b0;
            r_pair   <= '0;
        end else if (i_accept) begin
            r_col    <= n_col;
            r_second <= n_second;
            r_pair   <= n_pair;
        end
    end

    // Line buffer: store chroma on the first line, fetch it on the second.
    // One beat either writes or reads, and a column is read only a full line
    // after its write, so no forwarding is needed.
    assign o_ram_we    = i_accept && !r_second;
    assign o_ram_re    = i_accept && r_second;
    assign o_ram_addr  = col_eff[AW-1:0];
    assign o_ram_wdata = {i_pix.chroma_red, i_pix.chroma_blue};

    // Beat info for the averaging stage
    always_comb begin
        o_meta.luma_first   = i_pix.luma_first;
        o_meta.luma_second  = i_pix.luma_second;
        o_meta.chroma_blue  = i_pix.chroma_blue;
        o_meta.chroma_red   = i_pix.chroma_red;
        o_meta.chroma_valid = r_second;
        o_meta.line_end     = last_col;
        o_meta.frame_end    = last_col && r_second && last_pair;
    end

endmodule

`default_nettype wire

### rtl/yuv420_avg.sv
// Read-data stage, chroma averaging and output register with handshake.
// Depends on yuv420_pkg.
`default_nettype none

module yuv420_avg
    import yuv420_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire t_meta              i_meta,
    input  wire logic [2*PIX_W-1:0] i_rdata,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_result                 o_out
);

    logic    r_s1_valid;
    t_meta   r_s1_meta;
    logic    r_out_valid;
    t_result r_out;

    logic       out_free;
    logic       s1_move;
    logic [PIX_W:0] u_sum;
    logic [PIX_W:0] v_sum;
    t_result    n_out;

    // Stage 1 moves on whenever the output register is empty or being drained
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_meta <= i_meta;
        end
    end

    // Average with the stored line, truncating
    always_comb begin
        u_sum = {1'b0, r_s1_meta.chroma_blue} + {1'b0, i_rdata[PIX_W-1:0]};
        v_sum = {1'b0, r_s1_meta.chroma_red} + {1'b0, i_rdata[2*PIX_W-1:PIX_W]};
        n_out.y_out_first  = r_s1_meta.luma_first;
        n_out.y_out_second = r_s1_meta.luma_second;
        n_out.u_average    = r_s1_meta.chroma_valid ? u_sum[PIX_W:1] : '0;
        n_out.v_average    = r_s1_meta.chroma_valid ? v_sum[PIX_W:1] : '0;
        n_out.chroma_valid = r_s1_meta.chroma_valid;
        n_out.line_end     = r_s1_meta.line_end;
        n_out.frame_end    = r_s1_meta.frame_end;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

### rtl/yuyv_to_planar_420_converter.sv
// Top level of the YUYV 4:2:2 to planar 4:2:0 converter.
// Depends on yuv420_pkg, yuv420_ctrl, yuv420_ram and yuv420_avg.
//
// Channel   Direction  Handshake                Payload
// s_*       in         i_s_tvalid / o_s_tready  tdata: Y0, U, Y1, V macropixel
// m_*       out        o_m_tvalid / i_m_tready  tdata: Y0, Y1, U avg, V avg; tlast; tuser
// cfg_*     in         i_cfg_valid / o_cfg_ready  index + 11-bit register value
//
// One macropixel per clock sustained while the output is not stalled; an input beat
// passes through the line buffer's registered read stage and then the output register.
// Synchronous active-low reset clears counters, registers and pipeline valids;
// the line buffer is not cleared and needs no sweep.
// Output stalls back up through the read stage; input stops only when both the
// read stage and the output register are full.
`default_nettype none

module yuyv_to_planar_420_converter
    import yuv420_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second, [31:24] chroma_red
    input  wire logic [4*PIX_W-1:0]   i_s_tdata,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // [7:0] y_out_first, [15:8] y_out_second, [23:16] u_average, [31:24] v_average
    output logic      [4*PIX_W-1:0]   o_m_tdata,
    // [0] chroma_valid, [1] frame_end
    output logic      [1:0]           o_m_tuser,
    output logic                      o_m_tlast,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_PAIRS);

    logic               accept;
    logic               in_ready;
    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_addr;
    logic [2*PIX_W-1:0] ram_wdata;
    logic [2*PIX_W-1:0] ram_rdata;
    t_meta              meta;
    t_result            result;

    assign accept      = i_s_tvalid && in_ready;
    assign o_s_tready  = in_ready;
    assign o_cfg_ready = 1'b1;

    yuv420_ctrl #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_pix       (t_pix'(i_s_tdata)),
        .o_ram_we    (ram_we),
        .o_ram_re    (ram_re),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .o_meta      (meta)
    );

    // U and V line buffer, one 16-bit word per column
    yuv420_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_PAIRS)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    yuv420_avg u_avg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_meta      (meta),
        .i_rdata     (ram_rdata),
        .o_in_ready  (in_ready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out       (result)
    );

    // Output packing
    assign o_m_tdata = {result.v_average, result.u_average,
                        result.y_out_second, result.y_out_first};
    assign o_m_tuser = {result.frame_end, result.chroma_valid};
    assign o_m_tlast = result.line_end;

endmodule

`default_nettype wire

### rtl/yuv420_checker.sv
// Port-level assertions for the converter, attached by bind.
// Depends on yuv420_pkg and yuyv_to_planar_420_converter.
`default_nettype none

module yuv420_checker
    import yuv420_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_s_tvalid,
    input wire logic               o_s_tready,
    input wire logic [4*PIX_W-1:0] o_m_tdata,
    input wire logic [1:0]         o_m_tuser,
    input wire logic               o_m_tlast,
    input wire logic               o_m_tvalid,
    input wire logic               i_m_tready
);

    // Frame end only on the last column of a chroma line
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tlast && o_m_tuser[0]))
        else $error("frame end outside last chroma column");

    // No chroma on the first line of a pair
    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[4*PIX_W-1:2*PIX_W] == '0))
        else $error("chroma nonzero on first line");

    // A new output beat follows an accepted input beat
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 2))
        else $error("output beat without matching input beat");

    // Stalled output beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("stalled output beat changed");

endmodule

bind yuyv_to_planar_420_converter yuv420_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

`default_nettype wire

### test/tb_yuyv_to_planar_420_converter.sv
// Testbench for the YUYV 4:2:2 to planar 4:2:0 converter: directed and random macropixel
// streams, with a line-buffer predictor checking every result beat. Needs yuv420_pkg
// and the converter RTL only.
`timescale 1ns / 100ps

module tb_yuyv_to_planar_420_converter;
    import yuv420_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int MAX_COLS     = MAX_PAIRS_DEF;
    localparam int TOTAL_ITEMS  = 1450;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_REPORTS  = 10;
    // worst case: every beat waits a long source gap and a long sink stall,
    // and every short burst is preceded by a register write with a full drain
    localparam int CYCLE_LIMIT  = 2000000;

    // indexes past the register list, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX_B = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic [4*PIX_W-1:0]   i_s_tdata   = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [4*PIX_W-1:0]   o_m_tdata;
    logic [1:0]           o_m_tuser;
    logic                 o_m_tlast;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    yuyv_to_planar_420_converter #(
        .MAX_PAIRS(MAX_COLS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: registers, chroma line stores, position counters
    logic [CFG_W-1:0] line_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [PIX_W-1:0] u_row [MAX_COLS];
    logic [PIX_W-1:0] v_row [MAX_COLS];
    int               col_pos;
    bit               on_second_line;
    int               pair_pos;
    int               cols_written;   // stores are always filled as a prefix from column 0

    t_result          planar_q[$];
    int               items_sent;
    int               beats_seen;
    int               fail_count;
    int               cycle_count;
    bit               sender_idles    = 1'b1;
    bit               receiver_stalls = 1'b1;
    int               sink_hold;

    // Clock
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int clamp_cfg(input logic [CFG_W-1:0] raw, input int hi);
        if (raw == 0)
            return 1;
        if (int'(raw) > hi)
            return hi;
        return int'(raw);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit enabled);
        int roll;
        if (!enabled)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_pix make_pix(input logic [7:0] y0, input logic [7:0] u,
                                      input logic [7:0] y1, input logic [7:0] v);
        t_pix px;
        px.luma_first  = y0;
        px.chroma_blue = u;
        px.luma_second = y1;
        px.chroma_red  = v;
        return px;
    endfunction

    function automatic logic [7:0] random_byte(input bit extremes);
        if (extremes)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // Predict one result beat and advance the line/pair counters
    function automatic t_result convert_macropixel(input t_pix px);
        t_result          r;
        int               width;
        int               height;
        int               col;
        bit               last_col;
        bit               last_pair;
        logic [PIX_W:0]   u_sum;
        logic [PIX_W:0]   v_sum;
        width     = clamp_cfg(line_width_reg, MAX_COLS);
        height    = clamp_cfg(frame_height_reg, int'(LINE_PAIR_LIMIT));
        col       = (col_pos >= width) ? width - 1 : col_pos;
        last_col  = (col + 1 >= width);
        last_pair = (pair_pos + 1 >= height);

        r              = '0;
        r.y_out_first  = px.luma_first;
        r.y_out_second = px.luma_second;
        r.chroma_valid = on_second_line;
        if (!on_second_line) begin
            u_row[col] = px.chroma_blue;
            v_row[col] = px.chroma_red;
            if (col + 1 > cols_written)
                cols_written = col + 1;
        end else begin
            u_sum       = px.chroma_blue + u_row[col];
            v_sum       = px.chroma_red + v_row[col];
            r.u_average = u_sum[PIX_W:1];
            r.v_average = v_sum[PIX_W:1];
        end
        r.line_end  = last_col;
        r.frame_end = last_col && on_second_line && last_pair;

        if (!last_col) begin
            col_pos = col + 1;
        end else begin
            col_pos = 0;
            if (!on_second_line) begin
                on_second_line = 1'b1;
            end else begin
                on_second_line = 1'b0;
                pair_pos       = last_pair ? 0 : pair_pos + 1;
            end
        end
        return r;
    endfunction

    // Send one macropixel beat, then an optional gap
    task automatic send_macropixel(input t_pix px);
        int gap;
        @(negedge i_clk);
        i_s_tdata  <= px;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        planar_q.push_back(convert_macropixel(px));
        items_sent++;
        gap = pick_gap(sender_idles);
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Stop the source and let every pending result drain
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (planar_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_PAIRS_PER_LINE:       line_width_reg   = value;
            CFG_LINE_PAIRS_PER_FRAME: frame_height_reg = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random sink backpressure
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            i_m_tready <= 1'b0;
            sink_hold--;
        end else begin
            i_m_tready <= 1'b1;
            if (receiver_stalls)
                sink_hold = pick_gap(1'b1);
        end
    end

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.y_out_first  = o_m_tdata[7:0];
            got.y_out_second = o_m_tdata[15:8];
            got.u_average    = o_m_tdata[23:16];
            got.v_average    = o_m_tdata[31:24];
            got.chroma_valid = o_m_tuser[0];
            got.frame_end    = o_m_tuser[1];
            got.line_end     = o_m_tlast;
            if (planar_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("beat %0d: unexpected result %h", beats_seen, got);
            end else begin
                want = planar_q.pop_front();
                if (got.y_out_first !== want.y_out_first ||
                    got.y_out_second !== want.y_out_second ||
                    got.u_average !== want.u_average ||
                    got.v_average !== want.v_average ||
                    got.chroma_valid !== want.chroma_valid ||
                    got.line_end !== want.line_end ||
                    got.frame_end !== want.frame_end) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("beat %0d: expected y0=%h y1=%h u=%h v=%h cv=%b le=%b fe=%b",
                                 beats_seen, want.y_out_first, want.y_out_second,
                                 want.u_average, want.v_average, want.chroma_valid,
                                 want.line_end, want.frame_end);
                        $display("beat %0d:      got y0=%h y1=%h u=%h v=%h cv=%b le=%b fe=%b",
                                 beats_seen, got.y_out_first, got.y_out_second,
                                 got.u_average, got.v_average, got.chroma_valid,
                                 got.line_end, got.frame_end);
                    end
                end
            end
            beats_seen++;
        end
    end

    // Defaults, byte extremes, truncating average, mid-line shrink on the first line
    task automatic test_defaults_and_extremes();
        send_macropixel(make_pix(8'h00, 8'h00, 8'h00, 8'h00));
        send_macropixel(make_pix(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_macropixel(make_pix(8'hAA, 8'h55, 8'h55, 8'hAA));
        send_macropixel(make_pix(8'h55, 8'hAA, 8'hAA, 8'h55));
        // column already past the new end: this beat closes the line
        write_register(CFG_PAIRS_PER_LINE, 11'd2);
        send_macropixel(make_pix(8'h01, 8'hFE, 8'h80, 8'h7F));
        send_macropixel(make_pix(8'h12, 8'hFF, 8'h34, 8'hFF));
        send_macropixel(make_pix(8'h56, 8'hFF, 8'h78, 8'h00));
    endtask

    // Zero registers act as one; pair count already past the frame height
    task automatic test_minimum_frame();
        write_register(CFG_PAIRS_PER_LINE, 11'd0);
        write_register(CFG_LINE_PAIRS_PER_FRAME, 11'd0);
        repeat (4)
            send_macropixel(make_pix(random_byte(0), random_byte(0),
                                     random_byte(0), random_byte(0)));
    endtask

    // Oversized and maximum registers, ignored indexes, then a shrink mid-line
    task automatic test_maximum_sizes();
        write_register(CFG_PAIRS_PER_LINE, 11'd2047);
        write_register(CFG_LINE_PAIRS_PER_FRAME, 11'd2047);
        repeat (6)
            send_macropixel(make_pix(random_byte(0), random_byte(0),
                                     random_byte(0), random_byte(0)));
        write_register(CFG_PAIRS_PER_LINE, 11'd1024);
        repeat (2)
            send_macropixel(make_pix(random_byte(0), random_byte(0),
                                     random_byte(0), random_byte(0)));
        write_register(CFG_SPARE_IDX_A, 11'd1);
        write_register(CFG_SPARE_IDX_B, 11'h7FF);
        send_macropixel(make_pix(random_byte(0), random_byte(0),
                                 random_byte(0), random_byte(0)));
        write_register(CFG_PAIRS_PER_LINE, 11'd3);
        repeat (4)
            send_macropixel(make_pix(random_byte(0), random_byte(0),
                                     random_byte(0), random_byte(0)));
    endtask

    // Pick a new register setting; never widen the second line past written columns
    task automatic reconfigure_random();
        int               pick;
        int               roll;
        logic [CFG_W-1:0] value;
        pick = $urandom_range(0, 9);
        roll = $urandom_range(0, 9);
        if (pick < 5) begin
            if (roll < 7)
                value = CFG_W'($urandom_range(1, 8));
            else if (roll < 9)
                value = CFG_W'($urandom_range(9, 40));
            else
                value = CFG_W'($urandom_range(0, 2047));
            if (on_second_line && clamp_cfg(value, MAX_COLS) > cols_written)
                value = CFG_W'($urandom_range(1, cols_written));
            write_register(CFG_PAIRS_PER_LINE, value);
        end else if (pick < 9) begin
            value = (roll < 7) ? CFG_W'($urandom_range(0, 4))
                               : CFG_W'($urandom_range(0, 2047));
            write_register(CFG_LINE_PAIRS_PER_FRAME, value);
        end else begin
            value = CFG_W'($urandom_range(0, 2047));
            write_register($urandom_range(0, 1) ? CFG_SPARE_IDX_A : CFG_SPARE_IDX_B, value);
        end
    endtask

    // Bursts of whole line pairs, plus short ragged runs that stop mid-line
    task automatic test_random_traffic();
        int count;
        int width;
        bit extremes;
        while (items_sent < TOTAL_ITEMS) begin
            sender_idles    = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 6)
                reconfigure_random();
            width    = clamp_cfg(line_width_reg, MAX_COLS);
            extremes = ($urandom_range(0, 7) == 0);
            if (width <= 40 && $urandom_range(0, 9) < 7)
                count = 2 * width * $urandom_range(1, 3);
            else
                count = $urandom_range(1, 30);
            // stop right at the item budget
            if (count > TOTAL_ITEMS - items_sent)
                count = TOTAL_ITEMS - items_sent;
            repeat (count)
                send_macropixel(make_pix(random_byte(extremes), random_byte(extremes),
                                         random_byte(extremes), random_byte(extremes)));
        end
    endtask

    initial begin
        line_width_reg   = PAIRS_PER_LINE_RESET;
        frame_height_reg = LINE_PAIRS_PER_FRAME_RESET;
        col_pos          = 0;
        on_second_line   = 1'b0;
        pair_pos         = 0;
        cols_written     = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults_and_extremes();
        test_minimum_frame();
        test_maximum_sizes();
        test_random_traffic();
        wait_drained();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
